// File: design/ptbs_pkg.sv
// ----------------------------------------------------------------------------
// Pulse timing bit slicer package
// Shared constants and the command and status types that link the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ptbs_pkg;

	// Capacity ceiling in bytes and symbol ceiling per pulse.
	localparam int MAX_CAP_BYTES         = 4096;
	localparam int MAX_SYMBOLS_PER_PULSE = 504;

	// Field widths.
	localparam int DUR_W    = 32;
	localparam int UNIT_W   = 16;
	localparam int CAP_W    = 13;
	localparam int CNT_W    = 16;
	localparam int INDEX_W  = 12;
	localparam int CFG_IX_W = 1;
	localparam int CFG_W    = 16;

	// The rounded dividend carries one bit more than the magnitude.
	localparam int DIVIDEND_W = DUR_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int SYM_W      = $clog2(MAX_SYMBOLS_PER_PULSE + 1);

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] REG_UNIT_TIME = 1'b0;
	localparam logic [CFG_IX_W-1:0] REG_CAPACITY  = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FILL,
		ST_CLOSE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic div_step;
		logic sym_load;
		logic fill_step;
		logic close_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mag_zero;
		logic div_done;
		logic fill_done;
		logic byte_full;
		logic out_free;
		logic frame_end;
	} status_t;

endpackage

// File: design/ptbs_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per step, for the symbol rounding.
// ----------------------------------------------------------------------------
module ptbs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              step,
	input  logic [ptbs_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [ptbs_pkg::UNIT_W-1:0]       divisor,
	output logic                              done,
	output logic [ptbs_pkg::DIVIDEND_W-1:0]   quotient
);
	import ptbs_pkg::*;

	logic [DIVIDEND_W-1:0] quo_q;
	logic [UNIT_W-1:0]     rem_q;
	logic [UNIT_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [UNIT_W:0]       trial;
	logic                  fits;

	// Bring down the next dividend bit and try a subtraction.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIVIDEND_W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step && cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? UNIT_W'(trial - {1'b0, dvs_q}) : trial[UNIT_W-1:0];
		end
	end

	assign done     = cnt_q == '0;
	assign quotient = quo_q;

endmodule

// File: design/ptbs_dp.sv
// ----------------------------------------------------------------------------
// Pulse slicer datapath
// Configuration, magnitude rounding, bit packing and the result register.
// ----------------------------------------------------------------------------
module ptbs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ptbs_pkg::CFG_IX_W-1:0]     cfg_index,
	input  logic [ptbs_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [ptbs_pkg::DUR_W-1:0] duration,
	input  logic                              frame_end,
	input  ptbs_pkg::cmd_t                    cmd,
	output ptbs_pkg::status_t                 status,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        out_byte,
	output logic [ptbs_pkg::INDEX_W-1:0]      byte_index,
	output logic [ptbs_pkg::CNT_W-1:0]        bit_total,
	output logic                              capacity_full,
	output logic                              frame_done,
	output logic                              run_last
);
	import ptbs_pkg::*;

	logic [UNIT_W-1:0]     unit_time_q;
	logic [CAP_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      bit_count_q;
	logic [7:0]            partial_q;
	logic [SYM_W-1:0]      sym_rem_q;
	logic                  high_q;
	logic                  mag_zero_q;
	logic                  frame_end_q;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic [INDEX_W-1:0]    byte_index_q;
	logic [CNT_W-1:0]      bit_total_q;
	logic                  capacity_full_q;
	logic                  frame_done_q;
	logic                  run_last_q;

	logic [DUR_W-1:0]      mag;
	logic [UNIT_W-1:0]     unit_eff;
	logic [DIVIDEND_W-1:0] dividend;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [SYM_W-1:0]      sym_count;

	logic [CAP_W-1:0]      cap_sat;
	logic [CNT_W-1:0]      limit;
	logic                  at_limit;
	logic [CNT_W-1:0]      space;
	logic [3:0]            space_clip;
	logic [3:0]            sym_clip;
	logic [2:0]            pos;
	logic [3:0]            room;
	logic [3:0]            take;
	logic [3:0]            end_pos;
	logic [7:0]            mask;
	logic [7:0]            new_byte;
	logic [CNT_W-1:0]      after;
	logic [SYM_W-1:0]      sym_after;
	logic                  partial_any;
	logic                  out_load;
	logic                  out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_time_q <= UNIT_W'(100);
			capacity_q  <= CAP_W'(4096);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_UNIT_TIME: unit_time_q <= cfg_data[UNIT_W-1:0];
				REG_CAPACITY:  capacity_q  <= cfg_data[CAP_W-1:0];
				default:       ;
			endcase
		end
	end

	// Magnitude and rounded dividend: (|d| + unit/2) / unit, unit of zero read as one.
	assign mag      = duration[DUR_W-1] ? DUR_W'(~duration + 1'b1) : DUR_W'(duration);
	assign unit_eff = (unit_time_q == '0) ? UNIT_W'(1) : unit_time_q;
	assign dividend = {1'b0, mag} + DIVIDEND_W'(unit_eff >> 1);

	ptbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accept),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (unit_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (quotient > DIVIDEND_W'(MAX_SYMBOLS_PER_PULSE)) begin
			sym_count = SYM_W'(MAX_SYMBOLS_PER_PULSE);
		end else if (quotient == '0) begin
			sym_count = SYM_W'(1);
		end else begin
			sym_count = quotient[SYM_W-1:0];
		end
	end

	// Bit limit of the frame.
	assign cap_sat  = (32'(capacity_q) > 32'(MAX_CAP_BYTES)) ? CAP_W'(MAX_CAP_BYTES)
	                                                          : capacity_q;
	assign limit    = {cap_sat, 3'b000};
	assign at_limit = bit_count_q >= limit;

	// One packing step writes up to the next byte boundary.
	assign space      = limit - bit_count_q;
	assign space_clip = at_limit ? 4'd0 : ((space > CNT_W'(8)) ? 4'd8 : space[3:0]);
	assign sym_clip   = (sym_rem_q > SYM_W'(8)) ? 4'd8 : sym_rem_q[3:0];
	assign pos        = bit_count_q[2:0];
	assign room       = 4'd8 - {1'b0, pos};

	always_comb begin
		take = room;
		if (sym_clip < take) begin
			take = sym_clip;
		end
		if (space_clip < take) begin
			take = space_clip;
		end
	end

	assign end_pos   = {1'b0, pos} + take;
	assign mask      = (8'hFF >> pos) & ~(8'hFF >> end_pos);
	assign new_byte  = partial_q | (high_q ? mask : 8'h00);
	assign after     = bit_count_q + CNT_W'(take);
	assign sym_after = sym_rem_q - SYM_W'(take);
	assign partial_any = pos != 3'd0;

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
			partial_q   <= '0;
		end else if (cmd.fill_step) begin
			bit_count_q <= after;
			partial_q   <= (end_pos == 4'd8) ? 8'h00 : new_byte;
		end else if (cmd.close_step) begin
			bit_count_q <= '0;
			partial_q   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			high_q      <= !duration[DUR_W-1] && duration != '0;
			mag_zero_q  <= duration == '0;
			frame_end_q <= frame_end;
		end
		if (cmd.sym_load) begin
			sym_rem_q <= sym_count;
		end else if (cmd.fill_step) begin
			sym_rem_q <= sym_after;
		end
	end

	// Result register.
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (cmd.fill_step && end_pos == 4'd8) || cmd.close_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A full byte of a request without a frame end is its last result when fewer
	// than eight symbols remain or the limit is reached, as no further byte can fill.
	always_ff @(posedge clk) begin
		if (cmd.close_step) begin
			out_byte_q      <= partial_any ? partial_q : 8'h00;
			byte_index_q    <= partial_any ? bit_count_q[INDEX_W+2:3] : '0;
			bit_total_q     <= bit_count_q;
			capacity_full_q <= at_limit;
			frame_done_q    <= 1'b1;
			run_last_q      <= 1'b1;
		end else if (out_load) begin
			out_byte_q      <= new_byte;
			byte_index_q    <= after[INDEX_W+2:3] - 1'b1;
			bit_total_q     <= after;
			capacity_full_q <= after >= limit;
			frame_done_q    <= 1'b0;
			run_last_q      <= !frame_end_q && (sym_after < SYM_W'(8) || after >= limit);
		end
	end

	// The full byte's index is (after - 1) / 8, and after is a multiple of eight there.

	assign status.mag_zero  = mag_zero_q;
	assign status.div_done  = div_done;
	assign status.fill_done = (sym_rem_q == '0) || at_limit;
	assign status.byte_full = end_pos == 4'd8;
	assign status.out_free  = out_free;
	assign status.frame_end = frame_end_q;

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign byte_index    = byte_index_q;
	assign bit_total     = bit_total_q;
	assign capacity_full = capacity_full_q;
	assign frame_done    = frame_done_q;
	assign run_last      = run_last_q;

endmodule

// File: design/ptbs_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse slicer controller
// Sequences acceptance, division, byte packing and the frame close.
// ----------------------------------------------------------------------------
module ptbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptbs_pkg::status_t   status,
	output ptbs_pkg::cmd_t      cmd
);
	import ptbs_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.mag_zero) begin
					state_next = ST_CLOSE;
				end else if (status.div_done) begin
					state_next = ST_FILL;
				end
			end
			ST_FILL: begin
				if (status.fill_done) begin
					state_next = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (!status.frame_end || status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DIVIDE: begin
				cmd.div_step = !status.mag_zero && !status.div_done;
				cmd.sym_load = !status.mag_zero && status.div_done;
			end
			ST_FILL: begin
				cmd.fill_step = !status.fill_done && (!status.byte_full || status.out_free);
			end
			ST_CLOSE: begin
				cmd.close_step = status.frame_end && status.out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: design/pulse_timing_bit_slicer_core.sv
// ----------------------------------------------------------------------------
// Pulse timing bit slicer core
// Turns signed pulse durations into MSB-first packed level bytes per frame.
// ----------------------------------------------------------------------------
// One request is taken at a time. A non-zero duration is accepted, then
// stepped through the serial divider that rounds the magnitude to whole
// symbol units (one quotient bit per cycle over a 33-bit dividend), then
// packed in steps, each of which writes the bits up to the next byte
// boundary, and ends in a closing state. A zero duration skips the divider
// and the packing. Packing stalls while a finished byte waits in the
// result register, so a slow consumer holds the request up. There is no
// clearing pass after reset.
module pulse_timing_bit_slicer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port: index 0 is the unit time, index 1 the capacity.
	input  logic                              cfg_write,
	input  logic [ptbs_pkg::CFG_IX_W-1:0]     cfg_index,
	input  logic [ptbs_pkg::CFG_W-1:0]        cfg_data,
	// Input requests.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ptbs_pkg::DUR_W-1:0] duration,
	input  logic                              frame_end,
	// Result requests.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_byte,
	output logic [ptbs_pkg::INDEX_W-1:0]      byte_index,
	output logic [ptbs_pkg::CNT_W-1:0]        bit_total,
	output logic                              capacity_full,
	output logic                              frame_done,
	output logic                              run_last
);
	import ptbs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The controller decides what happens each cycle; the datapath holds
	// every value, including the single result register that lets the next
	// request in while a finished result is still waiting to be taken.
	ptbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ptbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.duration      (duration),
		.frame_end     (frame_end),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.byte_index    (byte_index),
		.bit_total     (bit_total),
		.capacity_full (capacity_full),
		.frame_done    (frame_done),
		.run_last      (run_last)
	);

endmodule

// File: design/ptbs_checker.sv
// ----------------------------------------------------------------------------
// Pulse slicer port checker
// Watches the top-level ports for ordering and payload rules of the results.
// ----------------------------------------------------------------------------
module ptbs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [7:0]                        out_byte,
	input  logic [ptbs_pkg::INDEX_W-1:0]      byte_index,
	input  logic [ptbs_pkg::CNT_W-1:0]        bit_total,
	input  logic                              frame_done,
	input  logic                              run_last
);
	import ptbs_pkg::*;

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(bit_total)
			&& $stable(byte_index) && $stable(frame_done))
	else $error("stalled result changed");

	// Only one request is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("request taken while another was in work");

	// The closing result always ends the work of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
	else $error("closing result not marked last");

	// A full byte always ends on a byte boundary of the bit count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> bit_total[2:0] == 3'd0 && bit_total != '0)
	else $error("full byte off a byte boundary");

	// A close with no partial bits carries an empty byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done && bit_total[2:0] == 3'd0 |-> out_byte == 8'h00
			&& byte_index == '0)
	else $error("empty close carries data");

endmodule

bind pulse_timing_bit_slicer_core ptbs_checker u_ptbs_checker (.*);

// File: verif/pulse_timing_bit_slicer_core_test.sv
// ----------------------------------------------------------------------------
// Pulse timing bit slicer core testbench
// Sends signed pulse durations under random idling on both handshakes. Every
// result request is checked field by field against an in-bench model of the
// rounding, MSB-first packing, capacity limit and frame close.
// ----------------------------------------------------------------------------
module pulse_timing_bit_slicer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ptbs_pkg::*;

	// Cycles allowed for a request that gives no result to finish before the
	// configuration is touched.
	localparam int SETTLE_CYCLES   = 200;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 20;

	// One expected result request.
	typedef struct {
		logic [7:0]         data_byte;
		logic [INDEX_W-1:0] index;
		logic [CNT_W-1:0]   total;
		logic               full;
		logic               done;
		logic               run_end;
	} slice_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_write     = 1'b0;
	logic [CFG_IX_W-1:0]      cfg_index     = REG_UNIT_TIME;
	logic [CFG_W-1:0]         cfg_data      = '0;
	logic                     in_valid      = 1'b0;
	logic                     in_ready;
	logic signed [DUR_W-1:0]  duration      = '0;
	logic                     frame_end     = 1'b0;
	logic                     out_valid;
	logic                     out_ready     = 1'b0;
	logic [7:0]               out_byte;
	logic [INDEX_W-1:0]       byte_index;
	logic [CNT_W-1:0]         bit_total;
	logic                     capacity_full;
	logic                     frame_done;
	logic                     run_last;

	// Model copy of the registers and of the frame state.
	logic [UNIT_W-1:0] unit_reg      = 16'd100;
	logic [CAP_W-1:0]  cap_reg       = 13'(MAX_CAP_BYTES);
	logic [CNT_W-1:0]  bits_in_frame = '0;
	logic [7:0]        open_byte     = '0;

	slice_t pending_slices[$];

	// When set, neither side idles; used for one steady stretch.
	logic no_idle = 1'b0;

	int error_count   = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int frames_closed = 0;
	int cfg_writes    = 0;

	pulse_timing_bit_slicer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.duration      (duration),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_index    (byte_index),
		.bit_total     (bit_total),
		.capacity_full (capacity_full),
		.frame_done    (frame_done),
		.run_last      (run_last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Idling and reporting
	// ------------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 65)
			return 0;
		else if (roll < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		// Keep the log readable if the block is badly broken.
		if (error_count <= 100)
			$display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, msg);
	endtask

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Builds a result from the current frame state; the fill level and the
	// full flag always reflect the bit count at the moment of emission.
	function automatic slice_t make_slice(input logic [7:0] data, input logic [INDEX_W-1:0] ix,
					      input logic done, input int unsigned limit);
		slice_t s;
		s.data_byte = data;
		s.index     = ix;
		s.total     = bits_in_frame;
		s.full      = (bits_in_frame >= limit);
		s.done      = done;
		s.run_end   = 1'b0;
		return s;
	endfunction

	// Works out every result that one accepted pulse request causes and queues
	// them in order. The last one carries the run_end mark.
	task automatic slice_pulse(input logic signed [DUR_W-1:0] dur, input logic closes);
		logic [DUR_W-1:0]  raw;
		logic [DUR_W-1:0]  negated;
		logic              high;
		longint unsigned   mag;
		longint unsigned   divisor;
		longint unsigned   symbols;
		longint unsigned   j;
		int unsigned       limit;
		logic [2:0]        pos;
		slice_t            batch[$];

		raw     = dur;
		negated = ~raw + 1'b1;
		high    = (raw != 0) && !raw[DUR_W-1];
		// The most negative value negates to itself, which is the right magnitude.
		mag     = raw[DUR_W-1] ? negated : raw;
		divisor = (unit_reg == 0) ? 1 : unit_reg;
		limit   = (cap_reg > MAX_CAP_BYTES) ? MAX_CAP_BYTES * 8 : cap_reg * 8;

		if (mag != 0) begin
			// Round to the nearest whole symbol, then clamp to one and to the ceiling.
			symbols = (mag + divisor / 2) / divisor;
			if (symbols < 1)
				symbols = 1;
			if (symbols > MAX_SYMBOLS_PER_PULSE)
				symbols = MAX_SYMBOLS_PER_PULSE;
			// Bits past the capacity are silently dropped.
			for (j = 0; j < symbols && bits_in_frame < limit; j++) begin
				pos = bits_in_frame[2:0];
				if (high)
					open_byte |= 8'h80 >> pos;
				bits_in_frame++;
				if (pos == 3'd7) begin
					batch.push_back(make_slice(open_byte,
								   INDEX_W'((bits_in_frame - 1'b1) >> 3),
								   1'b0, limit));
					open_byte = '0;
				end
			end
		end

		if (closes) begin
			// The closing result carries the padded partial byte if there is one,
			// otherwise a zero byte at index zero.
			if (bits_in_frame[2:0] != 0)
				batch.push_back(make_slice(open_byte, INDEX_W'(bits_in_frame >> 3),
							   1'b1, limit));
			else
				batch.push_back(make_slice(8'h00, '0, 1'b1, limit));
			bits_in_frame = '0;
			open_byte     = '0;
		end

		if (batch.size() > 0)
			batch[batch.size() - 1].run_end = 1'b1;
		foreach (batch[i])
			pending_slices.push_back(batch[i]);
	endtask

	// ------------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------------

	// Sends one pulse request. Valid is only lowered when a gap is taken, so it
	// is never lowered and raised within the same time step.
	task automatic send_pulse(input logic signed [DUR_W-1:0] dur, input logic closes);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		duration  <= dur;
		frame_end <= closes;
		do
			@(posedge clk);
		while (!in_ready);
		slice_pulse(dur, closes);
		items_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Holds the sender back until every expected result has been checked.
	task automatic wait_for_results();
		release_input();
		while (pending_slices.size() != 0)
			@(posedge clk);
	endtask

	// Brings the block to idle before a register write. A request that gives
	// no result may still be in the divider once the queue has emptied.
	task automatic settle_block();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= data;
		if (ix == REG_UNIT_TIME)
			unit_reg = data;
		else
			cap_reg = data[CAP_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result side: random back-pressure and the checker
	// ------------------------------------------------------------------------

	initial begin : result_sink
		int hold;
		forever begin
			@(negedge clk);
			hold = pick_gap();
			if (hold == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	task automatic check_result();
		slice_t want;
		results_seen++;
		if (frame_done === 1'b1)
			frames_closed++;
		if (pending_slices.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected (byte %02h index %0d)",
						  out_byte, byte_index));
		end else begin
			want = pending_slices.pop_front();
			if (out_byte !== want.data_byte)
				report_mismatch($sformatf("out_byte %02h, expected %02h",
							  out_byte, want.data_byte));
			if (byte_index !== want.index)
				report_mismatch($sformatf("byte_index %0d, expected %0d",
							  byte_index, want.index));
			if (bit_total !== want.total)
				report_mismatch($sformatf("bit_total %0d, expected %0d",
							  bit_total, want.total));
			if (capacity_full !== want.full)
				report_mismatch($sformatf("capacity_full %b, expected %b",
							  capacity_full, want.full));
			if (frame_done !== want.done)
				report_mismatch($sformatf("frame_done %b, expected %b",
							  frame_done, want.done));
			if (run_last !== want.run_end)
				report_mismatch($sformatf("run_last %b, expected %b",
							  run_last, want.run_end));
		end
	endtask

	// Outputs are sampled at the rising edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			check_result();
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset settings: a unit of 100 and the full capacity. Covers the rounding
	// boundary, the floor of one symbol, a zero duration on its own and with a
	// frame end, symbol saturation at both signs and at the most negative
	// value, and a close with and without a partial byte.
	task automatic test_reset_defaults();
		send_pulse(32'sd100, 1'b0);
		send_pulse(-32'sd149, 1'b0);
		send_pulse(32'sd150, 1'b0);
		send_pulse(32'sd1, 1'b0);
		send_pulse(32'sd0, 1'b0);
		send_pulse(-32'sd250, 1'b0);
		send_pulse(32'sd2147483647, 1'b0);
		send_pulse(-32'sd2147483647, 1'b1);
		send_pulse(32'sd0, 1'b1);
		send_pulse(32'h8000_0000, 1'b0);
		send_pulse(32'sd50, 1'b1);
		send_pulse(32'sd49, 1'b1);
	endtask

	// A unit of zero behaves as one; the widest unit checks rounding just
	// below and at a half symbol.
	task automatic test_unit_extremes();
		settle_block();
		write_register(REG_UNIT_TIME, 16'd0);
		send_pulse(32'sd3, 1'b0);
		send_pulse(-32'sd5, 1'b1);
		settle_block();
		write_register(REG_UNIT_TIME, 16'hFFFF);
		send_pulse(32'sd32767, 1'b0);
		send_pulse(-32'sd32768, 1'b0);
		send_pulse(32'sd98302, 1'b0);
		send_pulse(32'sd98303, 1'b1);
	endtask

	// Capacity of one byte (written with stray upper bits), of zero, above the
	// ceiling, and lowered in the middle of a frame.
	task automatic test_capacity_limits();
		settle_block();
		write_register(REG_UNIT_TIME, 16'd1);
		write_register(REG_CAPACITY, 16'hE001);
		send_pulse(32'sd12, 1'b0);
		send_pulse(-32'sd3, 1'b1);
		settle_block();
		write_register(REG_CAPACITY, 16'd0);
		send_pulse(32'sd5, 1'b1);
		settle_block();
		write_register(REG_CAPACITY, 16'd8191);
		send_pulse(32'sd20, 1'b0);
		settle_block();
		// The frame already holds 20 bits, more than the new limit of 16.
		write_register(REG_CAPACITY, 16'd2);
		send_pulse(-32'sd4, 1'b1);
	endtask

	// Phases of random traffic, each under its own register setting. Most of
	// it is frames of mostly alternating pulses near whole symbol counts, with
	// some repeated levels; the rest is raw 32-bit noise and zero durations.
	task automatic test_random_frames();
		logic [UNIT_W-1:0]       unit_sel;
		logic [CFG_W-1:0]        cap_sel;
		logic signed [DUR_W-1:0] dur;
		logic                    level;
		logic                    closes;
		longint unsigned         u;
		longint unsigned         mag;
		int                      phase_items;
		int                      pulses;
		int                      k;
		int                      roll;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					unit_sel = 16'd100;
					cap_sel  = CFG_W'(MAX_CAP_BYTES);
				end
				1: begin
					unit_sel = 16'd1;
					cap_sel  = CFG_W'($urandom_range(1, 8));
				end
				2: begin
					unit_sel = UNIT_W'($urandom_range(1, 65535));
					cap_sel  = CFG_W'($urandom_range(0, 8191));
				end
				3: begin
					unit_sel = 16'hFFFF;
					cap_sel  = CFG_W'(MAX_CAP_BYTES);
				end
				4: begin
					unit_sel = UNIT_W'($urandom_range(2, 500));
					cap_sel  = CFG_W'($urandom_range(1, 64));
				end
				default: begin
					unit_sel = 16'd0;
					cap_sel  = 16'd8191;
				end
			endcase
			settle_block();
			write_register(REG_UNIT_TIME, unit_sel);
			write_register(REG_CAPACITY, cap_sel);
			// One phase runs with no idling on either side.
			no_idle = (phase == 2);
			u = (unit_sel == 0) ? 1 : unit_sel;
			phase_items = 0;

			while (phase_items < ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) begin
					pulses = $urandom_range(1, 8);
					level  = 1'($urandom_range(0, 1));
					for (int p = 0; p < pulses; p++) begin
						// Mostly short runs, sometimes past the symbol ceiling.
						k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 700)
										: $urandom_range(1, 9);
						// Jitter of up to half a unit either side of the ideal.
						mag = longint'(k) * u + $urandom_range(0, int'(u)) - u / 2;
						dur = mag[DUR_W-1:0];
						if (!level)
							dur = -dur;
						send_pulse(dur, p == pulses - 1);
						if ($urandom_range(0, 4) != 0)
							level = !level;
					end
					phase_items += pulses;
					// Now and then the sender waits for the block to drain.
					if ($urandom_range(0, 9) == 0)
						wait_for_results();
				end else if (roll < 92) begin
					send_pulse($urandom, 1'($urandom_range(0, 1)));
					phase_items++;
				end else begin
					closes = 1'($urandom_range(0, 1));
					send_pulse('0, closes);
					phase_items += closes;
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_unit_extremes();
		test_capacity_limits();
		test_random_frames();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d pulse requests; checked %0d result requests over %0d frames",
			 items_sent, results_seen, frames_closed);
		$display("after %0d register writes, covering rounding edges, the symbol ceiling,",
			 cfg_writes);
		$display("unit and capacity extremes and mid-frame capacity cuts.");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results still expected.", pending_slices.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
